[hw/rtl/bitmap_text_blitter_top_defines.svh]
// Assertion macros for the bitmap text blitter RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef BITMAP_TEXT_BLITTER_TOP_DEFINES_SVH
`define BITMAP_TEXT_BLITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BTB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("btb assertion failed");
`define BTB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("btb assertion failed");
`else
`define BTB_ASSERT_IMP(lbl, ante, cons)
`define BTB_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hw/rtl/btb_pkg.sv]
// Shared types and constants of the bitmap text blitter.
// No dependencies.
`timescale 1ns / 1ps
package btb_pkg;

	localparam int GRID      = 16;
	localparam int ROW_BITS  = 4;
	localparam int BUF_LIMIT = 4096;

	typedef enum logic [1:0] {
		CMD_BEGIN      = 2'd0,
		CMD_LOAD_WIDTH = 2'd1,
		CMD_LOAD_PIXEL = 2'd2,
		CMD_DRAW       = 2'd3
	} btb_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PIX_MERGE,
		ST_DRAW_HDR,
		ST_DRAW_ROWS
	} btb_state_t;

	localparam logic [2:0] REG_GLYPH_COUNT   = 3'd0;
	localparam logic [2:0] REG_GLYPH_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_TRANSPARENT   = 3'd2;
	localparam logic [2:0] REG_DRAW_COLOR    = 3'd3;
	localparam logic [2:0] REG_ORIGIN_X      = 3'd4;
	localparam logic [2:0] REG_ORIGIN_Y      = 3'd5;
	localparam logic [2:0] REG_BUFFER_WIDTH  = 3'd6;
	localparam logic [2:0] REG_BUFFER_HEIGHT = 3'd7;

	typedef struct packed {
		logic [8:0]  glyph_count;
		logic [4:0]  glyph_height;
		logic [7:0]  transparent_value;
		logic [7:0]  draw_color;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [12:0] buffer_width;
		logic [12:0] buffer_height;
	} btb_cfg_t;

endpackage

[hw/rtl/btb_ram.sv]
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module btb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                      wdata,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[hw/rtl/btb_regs.sv]
// APB register file holding the blitter configuration.
// Depends on btb_pkg.
`timescale 1ns / 1ps
module btb_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output btb_pkg::btb_cfg_t cfg
);
	import btb_pkg::*;

	btb_cfg_t   cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_count       <= '0;
			cfg_q.glyph_height      <= 5'd16;
			cfg_q.transparent_value <= '0;
			cfg_q.draw_color        <= 8'd255;
			cfg_q.origin_x          <= '0;
			cfg_q.origin_y          <= '0;
			cfg_q.buffer_width      <= '0;
			cfg_q.buffer_height     <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_GLYPH_COUNT:   cfg_q.glyph_count       <= pwdata[8:0];
				REG_GLYPH_HEIGHT:  cfg_q.glyph_height      <= pwdata[4:0];
				REG_TRANSPARENT:   cfg_q.transparent_value <= pwdata[7:0];
				REG_DRAW_COLOR:    cfg_q.draw_color        <= pwdata[7:0];
				REG_ORIGIN_X:      cfg_q.origin_x          <= pwdata[15:0];
				REG_ORIGIN_Y:      cfg_q.origin_y          <= pwdata[15:0];
				REG_BUFFER_WIDTH:  cfg_q.buffer_width      <= pwdata[12:0];
				REG_BUFFER_HEIGHT: cfg_q.buffer_height     <= pwdata[12:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_GLYPH_COUNT:   prdata = 32'(cfg_q.glyph_count);
			REG_GLYPH_HEIGHT:  prdata = 32'(cfg_q.glyph_height);
			REG_TRANSPARENT:   prdata = 32'(cfg_q.transparent_value);
			REG_DRAW_COLOR:    prdata = 32'(cfg_q.draw_color);
			REG_ORIGIN_X:      prdata = 32'(cfg_q.origin_x);
			REG_ORIGIN_Y:      prdata = 32'(cfg_q.origin_y);
			REG_BUFFER_WIDTH:  prdata = 32'(cfg_q.buffer_width);
			REG_BUFFER_HEIGHT: prdata = 32'(cfg_q.buffer_height);
		endcase
	end

endmodule

[hw/rtl/bitmap_text_blitter_top.sv]
// Bitmap text blitter top level: glyph stores, draw sequencer, result pipeline.
// Depends on btb_pkg, btb_regs, btb_ram and bitmap_text_blitter_top_defines.svh.
//
// Channel   Handshake                 Payload
// command   start / busy              command, glyph_index, pixel_row, pixel_col,
//                                     load_value, has_bitmap
// result    strobe (one cycle)        row_y, start_x, write_mask, color, last
// config    APB psel/penable/pready   paddr, pwdata, prdata
//
// Begin and width load act in the accepting cycle; a pixel load does a row read,
// then a merged write of the 16-pixel row word.
// A skipped draw stays idle, an absent or fully clipped glyph visits the header
// state only, and a drawn glyph reads each row up to the last one in the buffer;
// its last result passes the v_s1 and output registers after the final row read.
// The pixel memory port, one glyph row per cycle, sets the draw rate.
// Glyph stores have no reset and no clearing pass; only loaded glyphs may be drawn,
// which the user must ensure, as the block does not enforce it. Results cannot be
// stalled; busy stays high until the last row read is in the output register.
`timescale 1ns / 1ps
`include "bitmap_text_blitter_top_defines.svh"
module bitmap_text_blitter_top #(
	parameter int MAX_GLYPHS       = 256,
	parameter int MAX_GLYPH_WIDTH  = 16,
	parameter int MAX_GLYPH_HEIGHT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [7:0]  glyph_index,
	input  logic [3:0]  pixel_row,
	input  logic [3:0]  pixel_col,
	input  logic [7:0]  load_value,
	input  logic        has_bitmap,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        strobe,
	output logic [11:0] row_y,
	output logic signed [15:0] start_x,
	output logic [15:0] write_mask,
	output logic [7:0]  color,
	output logic        last
);
	import btb_pkg::*;

	localparam int GW        = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int WW        = $clog2(MAX_GLYPH_WIDTH + 1);
	localparam int ROW_LIMIT = (MAX_GLYPH_HEIGHT < GRID) ? MAX_GLYPH_HEIGHT : GRID;
	localparam int PIX_DEPTH = MAX_GLYPHS * GRID;
	localparam int PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;

	btb_cfg_t   cfg;
	btb_state_t state_q, state_d;

	logic                accept, idx_ok, draw_ok;
	logic [GW-1:0]       gidx;
	logic [GW-1:0]       gidx_q;
	logic [3:0]          pcol_q;
	logic [7:0]          pval_q;
	logic [PIX_AW-1:0]   ld_addr, paddr_q, row_addr, pix_addr;
	logic [GW+3:0]       ld_addr_w, row_addr_w;
	logic                wid_we, pix_we;
	logic [WW-1:0]       width_sat;
	logic [WW:0]         wid_wdata, wid_rdata;
	logic [GRID*8-1:0]   pix_wdata, pix_rdata;
	logic [WW-1:0]       gw;
	logic                present;
	logic [12:0]         bw_sat, bh_sat;
	logic [4:0]          rows;
	logic [15:0]         colok_d, rowok_d, opaque;
	logic [15:0]         colok_q, rowok_q, pen_q, start_q;
	logic [3:0]          row_q;
	logic                last_now, issue;
	logic                v_s1, last_s1;
	logic [11:0]         rowy_s1;
	logic                strobe_s2, last_s2;
	logic [11:0]         rowy_s2;
	logic [15:0]         start_s2, mask_s2;
	logic [7:0]          color_s2;

	btb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign busy    = (state_q != ST_IDLE) || v_s1;
	assign accept  = start && !busy;
	assign idx_ok  = 9'(glyph_index) < 9'(MAX_GLYPHS);
	assign draw_ok = idx_ok && (9'(glyph_index) < cfg.glyph_count);
	assign gidx    = glyph_index[GW-1:0];

	assign ld_addr_w  = {gidx, pixel_row};
	assign ld_addr    = ld_addr_w[PIX_AW-1:0];
	assign row_addr_w = {gidx_q, row_q};
	assign row_addr   = row_addr_w[PIX_AW-1:0];

	assign width_sat = (load_value > 8'(MAX_GLYPH_WIDTH)) ? WW'(MAX_GLYPH_WIDTH)
	                                                      : load_value[WW-1:0];
	assign wid_wdata = {has_bitmap, width_sat};
	assign gw        = wid_rdata[WW-1:0];
	assign present   = wid_rdata[WW];

	btb_ram #(.WIDTH(WW + 1), .DEPTH(MAX_GLYPHS)) u_width_ram (
		.clk   (clk),
		.we    (wid_we),
		.addr  (gidx),
		.wdata (wid_wdata),
		.rdata (wid_rdata)
	);

	btb_ram #(.WIDTH(GRID * 8), .DEPTH(PIX_DEPTH)) u_pixel_ram (
		.clk   (clk),
		.we    (pix_we),
		.addr  (pix_addr),
		.wdata (pix_wdata),
		.rdata (pix_rdata)
	);

	// merge the loaded byte into the row word read in the previous cycle
	always_comb begin
		for (int c = 0; c < GRID; c++) begin
			pix_wdata[c*8 +: 8] = (4'(c) == pcol_q) ? pval_q : pix_rdata[c*8 +: 8];
			opaque[c]           = pix_rdata[c*8 +: 8] != cfg.transparent_value;
		end
	end

	assign bw_sat = (cfg.buffer_width > 13'(BUF_LIMIT)) ? 13'(BUF_LIMIT) : cfg.buffer_width;
	assign bh_sat = (cfg.buffer_height > 13'(BUF_LIMIT)) ? 13'(BUF_LIMIT)
	                                                     : cfg.buffer_height;
	assign rows   = (cfg.glyph_height > 5'(ROW_LIMIT)) ? 5'(ROW_LIMIT) : cfg.glyph_height;

	// per-column and per-row clip vectors for the glyph being drawn
	always_comb begin
		logic signed [17:0] px, py;
		for (int c = 0; c < GRID; c++) begin
			px = $signed({{2{pen_q[15]}}, pen_q}) + 18'(c);
			py = $signed({{2{cfg.origin_y[15]}}, cfg.origin_y}) + 18'(c);
			colok_d[c] = (8'(c) < 8'(gw)) && !px[17] && (px < $signed({5'b0, bw_sat}));
			rowok_d[c] = (5'(c) < rows) && !py[17] && (py < $signed({5'b0, bh_sat}));
		end
	end

	assign last_now = (rowok_q >> row_q) == 16'd1;

	always_comb begin
		state_d  = state_q;
		wid_we   = 1'b0;
		pix_we   = 1'b0;
		pix_addr = paddr_q;
		issue    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pix_addr = ld_addr;
				if (accept) begin
					unique case (btb_cmd_t'(command))
						CMD_BEGIN: begin
						end
						CMD_LOAD_WIDTH: wid_we = idx_ok;
						CMD_LOAD_PIXEL: begin
							if (idx_ok) state_d = ST_PIX_MERGE;
						end
						CMD_DRAW: begin
							if (draw_ok) state_d = ST_DRAW_HDR;
						end
					endcase
				end
			end
			ST_PIX_MERGE: begin
				pix_we  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DRAW_HDR: begin
				state_d = (present && (rowok_d != '0)) ? ST_DRAW_ROWS : ST_IDLE;
			end
			ST_DRAW_ROWS: begin
				pix_addr = row_addr;
				issue    = rowok_q[row_q];
				if (last_now) state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pen_q     <= '0;
			v_s1      <= 1'b0;
			strobe_s2 <= 1'b0;
		end else begin
			state_q   <= state_d;
			v_s1      <= issue;
			strobe_s2 <= v_s1;
			if (accept && (command == CMD_BEGIN)) begin
				pen_q <= cfg.origin_x;
			end else if (state_q == ST_DRAW_HDR) begin
				pen_q <= pen_q + 16'(gw);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gidx_q  <= gidx;
			pcol_q  <= pixel_col;
			pval_q  <= load_value;
			paddr_q <= ld_addr;
		end
		if (state_q == ST_DRAW_HDR) begin
			colok_q <= colok_d;
			rowok_q <= rowok_d;
			start_q <= pen_q;
			row_q   <= '0;
		end else if (state_q == ST_DRAW_ROWS) begin
			row_q <= row_q + 4'd1;
		end
		last_s1  <= last_now;
		rowy_s1  <= cfg.origin_y[11:0] + 12'(row_q);
		rowy_s2  <= rowy_s1;
		mask_s2  <= colok_q & opaque;
		last_s2  <= last_s1;
		start_s2 <= start_q;
		color_s2 <= cfg.draw_color;
	end

	assign strobe     = strobe_s2;
	assign row_y      = rowy_s2;
	assign start_x    = $signed(start_s2);
	assign write_mask = mask_s2;
	assign color      = color_s2;
	assign last       = last_s2;

	`BTB_ASSERT_IMP(a_last_ends_draw, strobe && last, state_q == ST_IDLE)
	`BTB_ASSERT_NXT(a_row_read_lands, issue, v_s1)
	`BTB_ASSERT_IMP(a_rows_nonempty, state_q == ST_DRAW_ROWS, rowok_q != '0)
	`BTB_ASSERT_IMP(a_merge_after_load, state_q == ST_PIX_MERGE,
		$past(accept && (command == CMD_LOAD_PIXEL)))

endmodule
